>>> rtl/core/vpk_pkg.sv
// ----------------------------------------------------------------------------
// vpk_pkg : shared constants and helpers for the kernel evaluator
// Fixed-point constants, CORDIC arctangent table, register indexes and the
// signed clamp used after the divide and after each partial-product multiply.
// ----------------------------------------------------------------------------
package vpk_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int RED_STEPS    = 13;   // 2^64 < 2*pi(Q49) << 13
  localparam int DIV_STEPS    = 64;
  localparam int PP_STEPS     = 4;

  localparam logic [63:0]        TWO_PI_Q49      = 64'd3537118876014220;
  localparam logic signed [34:0] TWO_PI_Q30      = 35'sd6746518852;
  localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic [63:0]        MAG_HALF  = 64'h8000_0000_0000_0000;

  // register indexes
  localparam logic [1:0] REG_LOWER_FREQ = 2'd0;
  localparam logic [1:0] REG_UPPER_FREQ = 2'd1;
  localparam logic [1:0] REG_NORM_SCALE = 2'd2;

  // which sine is in flight
  localparam logic [1:0] SEL_SUM  = 2'd0;
  localparam logic [1:0] SEL_DIFF = 2'd1;
  localparam logic [1:0] SEL_HALF = 2'd2;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } clamp_t;

  function automatic clamp_t clamp_mag(input logic [63:0] m, input logic over,
                                       input logic neg);
    clamp_t r;
    r.sat = 1'b0;
    r.val = signed'(m);
    if (neg) begin
      if (over || (m > MAG_HALF)) begin
        r.sat = 1'b1;
        r.val = S64_MIN;
      end else begin
        r.val = signed'(64'(-m));
      end
    end else if (over || m[63]) begin
      r.sat = 1'b1;
      r.val = S64_MAX;
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'd843314857;
      5'd1:  a = 32'd497837830;
      5'd2:  a = 32'd263043837;
      5'd3:  a = 32'd133525159;
      5'd4:  a = 32'd67021687;
      5'd5:  a = 32'd33543516;
      5'd6:  a = 32'd16775851;
      5'd7:  a = 32'd8388437;
      5'd8:  a = 32'd4194283;
      5'd9:  a = 32'd2097149;
      5'd10: a = 32'd1048576;
      5'd11: a = 32'd524288;
      5'd12: a = 32'd262144;
      5'd13: a = 32'd131072;
      5'd14: a = 32'd65536;
      5'd15: a = 32'd32768;
      5'd16: a = 32'd16384;
      5'd17: a = 32'd8192;
      5'd18: a = 32'd4096;
      5'd19: a = 32'd2048;
      5'd20: a = 32'd1024;
      5'd21: a = 32'd512;
      5'd22: a = 32'd256;
      5'd23: a = 32'd128;
      5'd24: a = 32'd64;
      5'd25: a = 32'd32;
      5'd26: a = 32'd16;
      5'd27: a = 32'd8;
      5'd28: a = 32'd4;
      5'd29: a = 32'd2;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/vallee_poussin_kernel_eval.sv
// ----------------------------------------------------------------------------
// vallee_poussin_kernel_eval : de la Vallee-Poussin kernel, fixed point
// Multiplies one kernel factor per coordinate into a running product and
// emits the scaled product on the last coordinate of each point.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one coordinate per transfer (Q8.24 rad) plus a last flag.
//   out_* : one Q32.32 kernel value per point, after its last coordinate,
//           with a flag set if any step of that point clamped.
//   cfg_* : write-only registers a, b and norm_scale; write while idle.
// Sequence
//   Each coordinate runs three sines (an angle step, a multiply for sum and
//   difference; 13 reduction steps; 1 fold; CORDIC_STEPS rotations) on one
//   shared CORDIC/subtractor, then a restoring divider (skipped on a zero
//   half sine or quotient overflow) and a 4-partial-product multiply on one
//   34x34 multiplier. The last coordinate adds a second multiply and the
//   output load. in_ready is high only while the sequencer is idle.
// Reset
//   Synchronous, active low: product back to 1.0, flags cleared, registers
//   to a = 0, b = 1.0, norm_scale = 1.0.
// Stall
//   A result waits in the output register; the next point is taken and
//   worked on meanwhile, and only its own result waits for the register.
// ----------------------------------------------------------------------------
module vallee_poussin_kernel_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coord,
  input  logic               in_last_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_kernel_value,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import vpk_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_ANG  = 16'b0000_0000_0000_0010,  // angle magnitude
    S_RED  = 16'b0000_0000_0000_0100,  // modulo 2*pi
    S_FOLD = 16'b0000_0000_0000_1000,  // fold into +-pi/2
    S_CRD  = 16'b0000_0000_0001_0000,  // CORDIC rotations
    S_NUM  = 16'b0000_0000_0010_0000,
    S_DEN  = 16'b0000_0000_0100_0000,
    S_SQB  = 16'b0000_0000_1000_0000,  // b*b (zero denominator)
    S_SQA  = 16'b0000_0001_0000_0000,  // a*a
    S_DCHK = 16'b0000_0010_0000_0000,  // quotient range check
    S_DIV  = 16'b0000_0100_0000_0000,
    S_FAC  = 16'b0000_1000_0000_0000,
    S_MSET = 16'b0001_0000_0000_0000,
    S_MPP  = 16'b0010_0000_0000_0000,  // partial products
    S_MSAT = 16'b0100_0000_0000_0000,
    S_EMIT = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [31:0] lower_r, upper_r;
  logic signed [63:0] norm_r;

  // item and sequencing
  logic signed [31:0] coord_r;
  logic               last_r;
  logic [1:0]         sel_r;
  logic [5:0]         cnt_r;
  logic               fin_r;

  // sine datapath
  logic [63:0]        red_r;
  logic               neg_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [34:0] cz_r;
  logic signed [33:0] sp_r, sq_r, sh_r;

  // divider / multiplier
  logic signed [63:0] num_r;
  logic [63:0]        den_r, rem_r, quo_r;
  logic [31:0]        dvd_r;
  logic signed [63:0] fac_r;
  logic [63:0]        ma_r, mb_r;
  logic               mneg_r;
  logic [127:0]       acc_r;

  // point state and output
  logic signed [63:0] rp_r;
  logic               sat_r;
  logic               out_valid_r;
  logic signed [63:0] out_kv_r;
  logic               out_sat_r;

  // ---------------- combinational helpers ----------------
  logic signed [32:0] sum_w, diff_w;
  logic [32:0]        sum_mag, diff_mag;
  logic [31:0]        ux;
  logic               xn;

  assign sum_w    = 33'(upper_r) + 33'(lower_r);
  assign diff_w   = 33'(upper_r) - 33'(lower_r);
  assign sum_mag  = sum_w[32]  ? 33'(-sum_w)  : 33'(sum_w);
  assign diff_mag = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
  assign xn       = coord_r[31];
  assign ux       = xn ? 32'(-coord_r) : 32'(coord_r);

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic [63:0]        mul_lo;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ANG: begin
        mul_a = signed'({1'b0, (sel_r == SEL_SUM) ? sum_mag : diff_mag});
        mul_b = signed'({2'b00, ux});
      end
      S_NUM: begin
        mul_a = sp_r;
        mul_b = sq_r;
      end
      S_DEN: begin
        mul_a = sh_r;
        mul_b = sh_r;
      end
      S_SQB: begin
        mul_a = 34'(upper_r);
        mul_b = 34'(upper_r);
      end
      S_SQA: begin
        mul_a = 34'(lower_r);
        mul_b = 34'(lower_r);
      end
      S_MPP: begin
        mul_a = signed'({2'b00, cnt_r[1] ? ma_r[63:32] : ma_r[31:0]});
        mul_b = signed'({2'b00, cnt_r[0] ? mb_r[63:32] : mb_r[31:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_lo = mul_p[63:0];

  // angle
  logic [63:0] ang_mag;
  logic        ang_neg;

  always_comb begin
    case (sel_r)
      SEL_SUM:  ang_neg = sum_w[32] ^ xn;
      SEL_DIFF: ang_neg = diff_w[32] ^ xn;
      default:  ang_neg = xn;
    endcase
    ang_mag = (sel_r == SEL_HALF) ? {8'b0, ux, 24'b0} : mul_lo;
  end

  // reduction step
  logic [63:0] red_cmp;
  assign red_cmp = TWO_PI_Q49 << cnt_r[3:0];

  // fold
  logic signed [34:0] z0, z1, z2;
  always_comb begin
    z0 = signed'({2'b00, red_r[51:19]});
    z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
    if (z1 > HALF_PI_Q30)       z2 = PI_Q30 - z1;
    else if (z1 < -HALF_PI_Q30) z2 = -PI_Q30 - z1;
    else                        z2 = z1;
  end

  // CORDIC rotation
  logic [4:0]         k;
  logic signed [33:0] xs, ys, cx_n, cy_n, sine;
  logic signed [34:0] at, cz_n;
  logic               crd_done;

  always_comb begin
    k  = cnt_r[4:0];
    xs = cx_r >>> k;
    ys = cy_r >>> k;
    at = signed'({3'b000, atan_q30(k)});
    if (!cz_r[34]) begin
      cx_n = cx_r - ys;
      cy_n = cy_r + xs;
      cz_n = cz_r - at;
    end else begin
      cx_n = cx_r + ys;
      cy_n = cy_r - xs;
      cz_n = cz_r + at;
    end
    sine     = neg_r ? -cy_n : cy_n;
    crd_done = (cnt_r == 6'(CORDIC_STEPS - 1));
  end

  // quotient range: q = |num|/den overflows if |num| >= den*(2^31+1)
  logic [63:0] num_mag;
  logic [94:0] ov_lim;
  logic        pre_ov;
  assign num_mag = num_r[63] ? 64'(-num_r) : 64'(num_r);
  assign ov_lim  = {den_r, 31'b0} + {31'b0, den_r};
  assign pre_ov  = {31'b0, num_mag} >= ov_lim;

  // restoring divide step
  logic [63:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_r[62:0], cnt_r[5] ? 1'b0 : dvd_r[31]};
  assign div_ge = rem_sh >= den_r;

  // partial product alignment
  logic [127:0] pp_term;
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pp_term = {64'b0, mul_lo};
      2'd3:    pp_term = {mul_lo, 64'b0};
      default: pp_term = {32'b0, mul_lo, 32'b0};
    endcase
  end

  clamp_t fac_cl, mul_cl;
  assign fac_cl = clamp_mag(quo_r, (quo_r == MAG_HALF) && (rem_r != '0), num_r[63]);
  assign mul_cl = clamp_mag(acc_r[95:32], |acc_r[127:96], mneg_r);

  logic emit_go;
  assign emit_go = !out_valid_r || out_ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_ANG;
      S_ANG:  state_nxt = S_RED;
      S_RED:  if (cnt_r == '0) state_nxt = S_FOLD;
      S_FOLD: state_nxt = S_CRD;
      S_CRD: begin
        if (crd_done) begin
          if (sel_r != SEL_HALF) state_nxt = S_ANG;
          else if (sine == '0)   state_nxt = S_SQB;
          else                   state_nxt = S_NUM;
        end
      end
      S_NUM:  state_nxt = S_DEN;
      S_DEN:  state_nxt = S_DCHK;
      S_SQB:  state_nxt = S_SQA;
      S_SQA:  state_nxt = S_MSET;
      S_DCHK: state_nxt = pre_ov ? S_MSET : S_DIV;
      S_DIV:  if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = S_FAC;
      S_FAC:  state_nxt = S_MSET;
      S_MSET: state_nxt = S_MPP;
      S_MPP:  if (cnt_r[1:0] == 2'(PP_STEPS - 1)) state_nxt = S_MSAT;
      S_MSAT: begin
        if (fin_r)       state_nxt = S_EMIT;
        else if (last_r) state_nxt = S_MSET;
        else             state_nxt = S_IDLE;
      end
      S_EMIT: if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_r     <= '0;
      upper_r     <= 32'sd16777216;
      norm_r      <= ONE_Q32;
      rp_r        <= ONE_Q32;
      sat_r       <= 1'b0;
      fin_r       <= 1'b0;
      sel_r       <= SEL_SUM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOWER_FREQ: lower_r <= signed'(cfg_wdata[31:0]);
          REG_UPPER_FREQ: upper_r <= signed'(cfg_wdata[31:0]);
          REG_NORM_SCALE: norm_r  <= signed'(cfg_wdata);
          default: ;
        endcase
      end

      // output register: loaded on emit, emptied by a transfer out
      if (state_r == S_EMIT && emit_go) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            coord_r <= in_coord;
            last_r  <= in_last_coord;
            sel_r   <= SEL_SUM;
          end
        end
        S_ANG: begin
          red_r <= ang_mag;
          neg_r <= ang_neg;
          cnt_r <= 6'(RED_STEPS - 1);
        end
        S_RED: begin
          if (red_r >= red_cmp) red_r <= red_r - red_cmp;
          cnt_r <= cnt_r - 6'd1;
        end
        S_FOLD: begin
          cx_r  <= CORDIC_GAIN_Q30;
          cy_r  <= '0;
          cz_r  <= z2;
          cnt_r <= '0;
        end
        S_CRD: begin
          cx_r  <= cx_n;
          cy_r  <= cy_n;
          cz_r  <= cz_n;
          cnt_r <= cnt_r + 6'd1;
          if (crd_done) begin
            case (sel_r)
              SEL_SUM:  sp_r <= sine;
              SEL_DIFF: sq_r <= sine;
              default:  sh_r <= sine;
            endcase
            if (sel_r != SEL_HALF) sel_r <= sel_r + 2'd1;
          end
        end
        S_NUM: num_r <= signed'(mul_lo);
        S_DEN: den_r <= mul_lo;
        S_SQB: num_r <= signed'(mul_lo);      // holds b*b
        S_SQA: fac_r <= (num_r - signed'(mul_lo)) >>> 16;
        S_DCHK: begin
          if (pre_ov) begin
            fac_r <= num_r[63] ? S64_MIN : S64_MAX;
            sat_r <= 1'b1;
          end
          rem_r <= {32'b0, num_mag[63:32]};
          dvd_r <= num_mag[31:0];
          quo_r <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          rem_r <= div_ge ? rem_sh - den_r : rem_sh;
          quo_r <= {quo_r[62:0], div_ge};
          dvd_r <= {dvd_r[30:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
        end
        S_FAC: begin
          fac_r <= fac_cl.val;
          sat_r <= sat_r | fac_cl.sat;
        end
        S_MSET: begin
          ma_r   <= fin_r ? (norm_r[63] ? 64'(-norm_r) : 64'(norm_r))
                          : (rp_r[63]   ? 64'(-rp_r)   : 64'(rp_r));
          mb_r   <= fin_r ? (rp_r[63]   ? 64'(-rp_r)   : 64'(rp_r))
                          : (fac_r[63]  ? 64'(-fac_r)  : 64'(fac_r));
          mneg_r <= fin_r ? (norm_r[63] ^ rp_r[63]) : (rp_r[63] ^ fac_r[63]);
          acc_r  <= '0;
          cnt_r  <= '0;
        end
        S_MPP: begin
          acc_r <= acc_r + pp_term;
          cnt_r <= cnt_r + 6'd1;
        end
        S_MSAT: begin
          sat_r <= sat_r | mul_cl.sat;
          if (fin_r) begin
            fac_r <= mul_cl.val;
          end else begin
            rp_r <= mul_cl.val;
            if (last_r) fin_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_kv_r    <= fac_r;
            out_sat_r   <= sat_r;
            rp_r        <= ONE_Q32;
            sat_r       <= 1'b0;
            fin_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kernel_value = out_kv_r;
  assign out_saturated    = out_sat_r;

endmodule

>>> rtl/core/vpk_checker.sv
// ----------------------------------------------------------------------------
// vpk_checker : port-level checks for the kernel evaluator
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module vpk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_kernel_value,
  input logic               out_saturated
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kernel_value)
      && $stable(out_saturated))
    else $error("result dropped or changed while stalled");

  // sequencer goes busy after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result only appears out of a busy sequencer
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work");

  // nothing valid straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vallee_poussin_kernel_eval vpk_checker u_vpk_checker (.*);

>>> test/vallee_poussin_kernel_eval_tb.sv
// ----------------------------------------------------------------------------
// vallee_poussin_kernel_eval_tb : self-checking bench for the kernel evaluator
// Drives coordinates over a valid/ready channel with random gaps and checks
// every kernel value and clamp flag against a bit-true predictor of the
// sine, divide and product arithmetic. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
module vallee_poussin_kernel_eval_tb;
  import vpk_pkg::*;

  localparam int  NUM_RANDOM  = 750;
  localparam int  IDLE_LIMIT  = 20000;   // cycles with no transfer at all
  localparam int  DRAIN_WAIT  = 400;     // about two coordinates of work
  localparam logic [63:0] TWO_PI_Q49_U = 64'd3537118876014220;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_coord = '0;
  logic               in_last_coord = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_kernel_value;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_wdata = '0;

  vallee_poussin_kernel_eval DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predictor state -----------------------------------------------------
  typedef struct packed {
    logic signed [63:0] value;
    logic               sat;
  } kernel_t;

  logic signed [63:0] a_q24, b_q24, scale_q32, prod_q32;
  logic               point_sat;
  kernel_t            kernels_due[$];
  int                 errors = 0;
  bit                 hold_output = 1'b0;   // long receiver hold-off

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // clamp a magnitude to a signed 64-bit value, flagging saturation
  function automatic logic signed [63:0] sclamp(input logic [63:0] m, input bit over,
                                                input bit neg, inout logic sat);
    if (neg) begin
      if (over || m > 64'h8000_0000_0000_0000) begin
        sat = 1'b1;
        return 64'sh8000_0000_0000_0000;
      end
      return 64'(-m);
    end
    if (over || m[63]) begin
      sat = 1'b1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return m;
  endfunction

  function automatic logic signed [63:0] cordic_sine(input logic [63:0] m, input bit neg);
    logic signed [63:0] z, x, y, t;
    logic signed [63:0] ang;
    z = 64'((m % TWO_PI_Q49_U) >> 19);
    x = 64'(CORDIC_GAIN_Q30);
    y = 0;
    if (z > 64'(PI_Q30)) z = z - 64'(TWO_PI_Q30);
    if (z > 64'(HALF_PI_Q30)) z = 64'(PI_Q30) - z;
    else if (z < -64'(HALF_PI_Q30)) z = -64'(PI_Q30) - z;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      ang = 64'(atan_q30(5'(i)));
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - ang;
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + ang;
      end
    end
    return neg ? -y : y;
  endfunction

  // |a|*|b| >> 32 with clamp
  function automatic logic signed [63:0] qmul(input logic signed [63:0] p,
                                              input logic signed [63:0] q, inout logic sat);
    logic [127:0] full;
    full = abs64(p) * abs64(q);
    return sclamp(full[95:32], full[127:96] != 0, (p < 0) != (q < 0), sat);
  endfunction

  function automatic logic signed [63:0] kernel_factor(input logic signed [31:0] xc,
                                                       inout logic sat);
    logic signed [63:0] s, d, sp, sq, sh, num, den;
    logic [63:0] ux, nm, q, rem;
    logic [127:0] wide;
    logic [127:0] qw;
    bit xn;
    s  = b_q24 + a_q24;
    d  = b_q24 - a_q24;
    xn = xc < 0;
    ux = abs64(64'(xc));
    sp = cordic_sine(abs64(s) * ux, (s < 0) != xn);
    sq = cordic_sine(abs64(d) * ux, (d < 0) != xn);
    sh = cordic_sine(ux << 24, xn);
    if (sh == 0) return (b_q24 * b_q24 - a_q24 * a_q24) >>> 16;
    num = sp * sq;
    den = sh * sh;
    nm  = abs64(num);
    q   = nm / den;
    if (q > 64'h8000_0000) return sclamp(0, 1'b1, num < 0, sat);
    wide = {nm, 32'b0};
    qw   = wide / den;
    rem  = 64'(wide % den);
    if (qw[63:0] == 64'h8000_0000_0000_0000 && rem != 0)
      return sclamp(qw[63:0], 1'b1, num < 0, sat);
    return sclamp(qw[63:0], 1'b0, num < 0, sat);
  endfunction

  // advance the predictor by one accepted coordinate
  task automatic predict_coord(input logic signed [31:0] xc, input logic lst);
    logic sat;
    logic signed [63:0] f;
    kernel_t k;
    sat = 1'b0;
    f = kernel_factor(xc, sat);
    prod_q32 = qmul(prod_q32, f, sat);
    point_sat |= sat;
    if (lst) begin
      k.value = qmul(scale_q32, prod_q32, sat);
      k.sat   = sat | point_sat;
      kernels_due.push_back(k);
      prod_q32  = ONE_Q32;
      point_sat = 1'b0;
    end
  endtask

  // ---- sender --------------------------------------------------------------
  task automatic send_coord(input logic signed [31:0] xc, input logic lst, input bit gaps);
    if (gaps && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 4))
        @(posedge clk);
    in_valid      <= 1'b1;
    in_coord      <= xc;
    in_last_coord <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_coord(xc, lst);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOWER_FREQ: a_q24 = 64'(signed'(v[31:0]));
      REG_UPPER_FREQ: b_q24 = 64'(signed'(v[31:0]));
      REG_NORM_SCALE: scale_q32 = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (kernels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'(signed'($urandom_range(0, 200)) - 100);   // near zero
      2:       return 32'($urandom_range(0, 3) * 105414357);          // multiples of 2*pi
      default: return 32'(signed'($urandom_range(0, 2 * 52707179)) - 52707179);
    endcase
  endfunction

  // ---- receiver and checker ------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (kernels_due.size() == 0) begin
          $display("%0t: unexpected kernel value %h sat %b", $time,
                   out_kernel_value, out_saturated);
          errors++;
        end else begin
          kernel_t k;
          k = kernels_due.pop_front();
          if (out_kernel_value !== k.value) begin
            $display("%0t: kernel_value expected %h actual %h", $time, k.value,
                     out_kernel_value);
            errors++;
          end
          if (out_saturated !== k.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, k.sat, out_saturated);
            errors++;
          end
        end
      end
      // mostly ready, short stalls, the odd long one; none while held off
      out_ready <= !hold_output && ($urandom_range(0, 3) != 0 ||
                   ($urandom_range(0, 40) == 0 ? 1'b0 : out_ready));
    end
  end

  // watchdog: cycles in which nothing moves on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- directed table ------------------------------------------------------
  typedef struct {
    logic signed [31:0] coord;
    logic               last;
    bit                 typed;       // expected value typed in below
    logic signed [63:0] want;
    logic               want_sat;
  } row_t;

  row_t rows[] = '{
    // x = 0: the half-angle sine is zero, so the factor is (b*b - a*a) >> 16, 1.0 at reset
    '{32'sd0, 1'b1, 1'b1, ONE_Q32, 1'b0},
    '{32'sd0, 1'b0, 1'b0, 0, 1'b0},
    '{32'sd0, 1'b1, 1'b1, ONE_Q32, 1'b0},
    '{32'sh7FFF_FFFF, 1'b1, 1'b0, 0, 1'b0},
    '{32'sh8000_0000, 1'b1, 1'b0, 0, 1'b0},
    '{32'sd1, 1'b1, 1'b0, 0, 1'b0},
    '{-32'sd1, 1'b1, 1'b0, 0, 1'b0},
    '{32'sd16777216, 1'b0, 1'b0, 0, 1'b0},
    '{-32'sd16777216, 1'b0, 1'b0, 0, 1'b0},
    '{32'sd52707179, 1'b1, 1'b0, 0, 1'b0},     // pi
    '{32'sd105414357, 1'b1, 1'b0, 0, 1'b0},    // 2*pi
    '{32'sh5555_5555, 1'b0, 1'b0, 0, 1'b0},
    '{32'shAAAA_AAAA, 1'b1, 1'b0, 0, 1'b0}
  };

  initial begin
    a_q24 = 0; b_q24 = 64'sd16777216; scale_q32 = ONE_Q32;
    prod_q32 = ONE_Q32; point_sat = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_coord(rows[i].coord, rows[i].last, 1'b0);
      if (rows[i].typed && rows[i].last &&
          (kernels_due[$].value !== rows[i].want || kernels_due[$].sat !== rows[i].want_sat)) begin
        $display("%0t: predictor expected %h actual %h", $time, rows[i].want,
                 kernels_due[$].value);
        errors++;
      end
    end
    drain();

    // register sweeps, extremes and fixed settings first, then random settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_LOWER_FREQ, 64'h8000_0000);
          write_reg(REG_UPPER_FREQ, 64'h7FFF_FFFF);
          write_reg(REG_NORM_SCALE, 64'h7FFF_FFFF_FFFF_FFFF);
        end
        1: begin
          write_reg(REG_LOWER_FREQ, 64'h7FFF_FFFF);
          write_reg(REG_UPPER_FREQ, 64'h8000_0000);
          write_reg(REG_NORM_SCALE, 64'h8000_0000_0000_0000);
        end
        2: begin
          write_reg(REG_LOWER_FREQ, 64'(16777216));
          write_reg(REG_UPPER_FREQ, 64'(16777216));
          write_reg(REG_NORM_SCALE, 64'd0);
        end
        3: begin
          write_reg(REG_LOWER_FREQ, 64'(32'd8388608));
          write_reg(REG_UPPER_FREQ, 64'(32'd50331648));
          write_reg(REG_NORM_SCALE, ONE_Q32);
        end
        default: begin
          write_reg(REG_LOWER_FREQ, {32'b0, $urandom});
          write_reg(REG_UPPER_FREQ, {32'b0, 32'($urandom_range(0, 80000000))});
          write_reg(REG_NORM_SCALE, {$urandom, $urandom});
        end
      endcase
      // points of one to four coordinates, random gaps
      for (int n = 0; n < NUM_RANDOM / 8; ) begin
        int len;
        len = $urandom_range(1, 4);
        for (int c = 0; c < len; c++) begin
          send_coord(rand_coord(), c == len - 1, 1'b1);
          n++;
        end
        // receiver holds off long while the sender keeps offering
        if (phase == 4 && n >= 20 && n < 24) begin
          hold_output = 1'b1;
          fork
            begin
              repeat (3000) @(posedge clk);
              hold_output = 1'b0;
            end
          join_none
        end
        // sender pauses until every result is back
        if (phase == 5 && n >= 40 && n < 44)
          while (kernels_due.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (errors == 0 && kernels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> vallee_poussin_kernel_eval.f
rtl/core/vpk_pkg.sv
rtl/core/vallee_poussin_kernel_eval.sv
rtl/core/vpk_checker.sv
test/vallee_poussin_kernel_eval_tb.sv
